[rtl/core/chd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge header decoder package
// Shared types, header offsets and constants of the header decoder.
// ----------------------------------------------------------------------------
package chd_pkg;

    localparam int MAX_IMAGE_BANKS = 512;

    localparam int OFFSET_W  = 5;
    localparam int BANKS_W   = 10;
    localparam int RAMB_W    = 5;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [OFFSET_W-1:0] OFF_COLOR   = 5'd15;
    localparam logic [OFFSET_W-1:0] OFF_SUPER   = 5'd18;
    localparam logic [OFFSET_W-1:0] OFF_TYPE    = 5'd19;
    localparam logic [OFFSET_W-1:0] OFF_ROMSZ   = 5'd20;
    localparam logic [OFFSET_W-1:0] OFF_RAMSZ   = 5'd21;
    localparam logic [OFFSET_W-1:0] OFF_VERSION = 5'd24;
    localparam logic [OFFSET_W-1:0] OFF_LAST    = 5'd25;

    localparam logic [7:0] SUM_BIAS       = 8'd25;
    localparam logic [7:0] TYPE_ROM_ONLY  = 8'h00;
    localparam logic [7:0] TYPE_MBC1      = 8'h01;
    localparam logic [7:0] TYPE_MBC1_ALT  = 8'hEA;
    localparam logic [7:0] COLOR_SUPPORT  = 8'h80;
    localparam logic [7:0] COLOR_ONLY     = 8'hC0;
    localparam logic [7:0] SUPER_ENABLED  = 8'h03;
    localparam logic [BANKS_W-1:0] MULTICART_BANKS = 10'd64;

    localparam logic [APB_AW-3:0] REG_IMAGE_BANKS = 1'b0;

    typedef enum logic [2:0] {
        MK_NONE  = 3'd0,
        MK_MBC1  = 3'd1,
        MK_MULTI = 3'd2,
        MK_MBC2  = 3'd3,
        MK_MBC3  = 3'd4,
        MK_MBC5  = 3'd5,
        MK_UNSUP = 3'd6
    } t_mapper_kind;

    typedef enum logic [1:0] {
        CM_MONO    = 2'd0,
        CM_SUPPORT = 2'd1,
        CM_ONLY    = 2'd2
    } t_color_mode;

    typedef struct packed {
        logic [7:0] sum;
        logic [7:0] color_flag;
        logic [7:0] super_flag;
        logic [7:0] cart_type;
        logic [7:0] rom_code;
        logic [7:0] ram_code;
        logic [7:0] version;
    } t_hdr_state;

    typedef struct packed {
        t_mapper_kind        mapper_kind;
        logic                has_battery;
        logic                has_clock;
        logic                has_rumble;
        logic [RAMB_W-1:0]   ram_banks;
        logic [BANKS_W-1:0]  rom_banks;
        t_color_mode         color_mode;
        logic                super_support;
        logic                header_ok;
        logic [7:0]          version;
        logic [7:0]          rom_size_code;
        logic [7:0]          ram_size_code;
    } t_hdr_result;

endpackage

[rtl/core/cartridge_header_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge header decoder
// Sums and decodes the cartridge header bytes 0x134 to 0x14D, one per beat.
// ----------------------------------------------------------------------------
// Usage:
// Send each header byte as one input beat with its offset from 0x134. Bytes
// with an offset above 25 are ignored, but a last mark on them still ends the
// header. The beat marked last yields one result beat, which appears on the
// output channel in the cycle after that beat is accepted. The block takes
// one beat every cycle unless stalled; the only path per beat is the capture
// and decode logic from the header state registers to the result register.
// The APB register image_banks gives the image size in 16 KiB units; the user
// must write it only while the block is idle; the block does not enforce it.
// Reset clears the checksum, the captured bytes and image_banks, and empties
// the result register. While the receiver stalls a held result, input beats
// are also held off, because the result register has a single entry.
// ----------------------------------------------------------------------------
module cartridge_header_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [chd_pkg::APB_AW-1:0]    paddr,
    input  logic [chd_pkg::APB_DW-1:0]    pwdata,
    output logic [chd_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [chd_pkg::OFFSET_W-1:0]  i_byte_offset,
    input  logic [7:0]                    i_header_byte,
    input  logic                          i_last_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [2:0]                    o_mapper_kind,
    output logic                          o_has_battery,
    output logic                          o_has_clock,
    output logic                          o_has_rumble,
    output logic [chd_pkg::RAMB_W-1:0]    o_ram_banks,
    output logic [chd_pkg::BANKS_W-1:0]   o_rom_banks,
    output logic [1:0]                    o_color_mode,
    output logic                          o_super_support,
    output logic                          o_header_ok,
    output logic [7:0]                    o_version,
    output logic [7:0]                    o_rom_size_code,
    output logic [7:0]                    o_ram_size_code
);

    logic                          w_accept;
    logic [chd_pkg::BANKS_W-1:0]   w_rom_banks;
    chd_pkg::t_hdr_state           w_state;
    chd_pkg::t_hdr_result          w_result;
    chd_pkg::t_hdr_result          r_result;
    logic                          r_out_valid;
    logic                          n_out_valid;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    chd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_rom_banks (w_rom_banks)
    );

    chd_capture u_capture (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_byte_offset (i_byte_offset),
        .i_header_byte (i_header_byte),
        .i_last_byte   (i_last_byte),
        .o_state       (w_state)
    );

    chd_decode u_decode (
        .i_state     (w_state),
        .i_rom_banks (w_rom_banks),
        .o_result    (w_result)
    );

    always_comb begin
        if (w_accept && i_last_byte) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_last_byte) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_mapper_kind   = r_result.mapper_kind;
    assign o_has_battery   = r_result.has_battery;
    assign o_has_clock     = r_result.has_clock;
    assign o_has_rumble    = r_result.has_rumble;
    assign o_ram_banks     = r_result.ram_banks;
    assign o_rom_banks     = r_result.rom_banks;
    assign o_color_mode    = r_result.color_mode;
    assign o_super_support = r_result.super_support;
    assign o_header_ok     = r_result.header_ok;
    assign o_version       = r_result.version;
    assign o_rom_size_code = r_result.rom_size_code;
    assign o_ram_size_code = r_result.ram_size_code;

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_last_byte |=> o_out_valid)
        else $error("accepted last beat did not produce a result");

    a_no_accept_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !w_accept)
        else $error("input beat accepted while the result register was stalled");

    a_rom_banks_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($onehot(o_rom_banks) || o_rom_banks == '0)
                        && o_rom_banks != chd_pkg::BANKS_W'(1))
        else $error("ROM bank count is not a power of two of at least two");

    a_mbc2_ram: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mapper_kind == chd_pkg::MK_MBC2 && o_ram_size_code == 8'h00
        |-> o_ram_banks == chd_pkg::RAMB_W'(1))
        else $error("MBC2 without RAM size code must report one RAM bank");

endmodule

[rtl/core/chd_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Header decoder configuration registers
// APB register for the image size and the ROM bank count derived from it.
// ----------------------------------------------------------------------------
module chd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [chd_pkg::APB_AW-1:0]    paddr,
    input  logic [chd_pkg::APB_DW-1:0]    pwdata,
    output logic [chd_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output logic [chd_pkg::BANKS_W-1:0]   o_rom_banks
);

    localparam int LIM_W = $clog2(chd_pkg::MAX_IMAGE_BANKS + 1) + 1;

    logic [chd_pkg::BANKS_W-1:0] r_image_banks;
    logic [chd_pkg::BANKS_W-1:0] r_rom_banks;
    logic [chd_pkg::BANKS_W-1:0] n_rom_banks;
    logic [chd_pkg::BANKS_W-1:0] w_wr_banks;
    logic [chd_pkg::BANKS_W-1:0] w_clamped;
    logic [chd_pkg::BANKS_W-1:0] w_smear;
    logic [chd_pkg::BANKS_W:0]   w_pow2;
    logic [LIM_W-1:0]            w_limit;
    logic                        w_write;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite && pready
                     && (paddr[chd_pkg::APB_AW-1:2] == chd_pkg::REG_IMAGE_BANKS);

    assign w_wr_banks = pwdata[chd_pkg::BANKS_W-1:0];
    assign w_limit    = LIM_W'(chd_pkg::MAX_IMAGE_BANKS);

    always_comb begin
        if (LIM_W'(w_wr_banks) > w_limit) begin
            w_clamped = w_limit[chd_pkg::BANKS_W-1:0];
        end else begin
            w_clamped = w_wr_banks;
        end
        w_smear = w_clamped - 1'b1;
        w_smear = w_smear | (w_smear >> 1);
        w_smear = w_smear | (w_smear >> 2);
        w_smear = w_smear | (w_smear >> 4);
        w_smear = w_smear | (w_smear >> 8);
        w_pow2  = {1'b0, w_smear} + 1'b1;
        if (w_clamped <= chd_pkg::BANKS_W'(2)) begin
            n_rom_banks = chd_pkg::BANKS_W'(2);
        end else begin
            n_rom_banks = w_pow2[chd_pkg::BANKS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_banks <= '0;
            r_rom_banks   <= chd_pkg::BANKS_W'(2);
        end else if (w_write) begin
            r_image_banks <= w_wr_banks;
            r_rom_banks   <= n_rom_banks;
        end
    end

    always_comb begin
        if (paddr[chd_pkg::APB_AW-1:2] == chd_pkg::REG_IMAGE_BANKS) begin
            prdata = chd_pkg::APB_DW'(r_image_banks);
        end else begin
            prdata = '0;
        end
    end

    assign o_rom_banks = r_rom_banks;

endmodule

[rtl/core/chd_capture.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Header byte capture
// Running checksum and captured header fields, updated on each input beat.
// ----------------------------------------------------------------------------
module chd_capture (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [chd_pkg::OFFSET_W-1:0]   i_byte_offset,
    input  logic [7:0]                     i_header_byte,
    input  logic                           i_last_byte,
    output chd_pkg::t_hdr_state            o_state
);

    chd_pkg::t_hdr_state r_state;
    chd_pkg::t_hdr_state n_state;
    chd_pkg::t_hdr_state w_updated;

    always_comb begin
        w_updated = r_state;
        if (i_byte_offset <= chd_pkg::OFF_LAST) begin
            w_updated.sum = r_state.sum + i_header_byte;
            unique case (i_byte_offset)
                chd_pkg::OFF_COLOR:   w_updated.color_flag = i_header_byte;
                chd_pkg::OFF_SUPER:   w_updated.super_flag = i_header_byte;
                chd_pkg::OFF_TYPE:    w_updated.cart_type  = i_header_byte;
                chd_pkg::OFF_ROMSZ:   w_updated.rom_code   = i_header_byte;
                chd_pkg::OFF_RAMSZ:   w_updated.ram_code   = i_header_byte;
                chd_pkg::OFF_VERSION: w_updated.version    = i_header_byte;
                default: begin
                end
            endcase
        end
        n_state = w_updated;
        if (i_last_byte) begin
            n_state.sum = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_accept) begin
            r_state <= n_state;
        end
    end

    assign o_state = w_updated;

endmodule

[rtl/core/chd_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Header field decoder
// Maps the captured header bytes to mapper kind, features and bank counts.
// ----------------------------------------------------------------------------
module chd_decode (
    input  chd_pkg::t_hdr_state             i_state,
    input  logic [chd_pkg::BANKS_W-1:0]     i_rom_banks,
    output chd_pkg::t_hdr_result            o_result
);

    logic [7:0]            w_type;
    chd_pkg::t_mapper_kind w_kind;
    logic [7:0]            w_check;

    always_comb begin
        if (i_state.cart_type != chd_pkg::TYPE_MBC1_ALT && i_state.rom_code == 8'h00) begin
            w_type = chd_pkg::TYPE_ROM_ONLY;
        end else begin
            w_type = i_state.cart_type;
        end

        unique case (w_type)
            8'h00, 8'h08, 8'h09:                      w_kind = chd_pkg::MK_NONE;
            8'h01, 8'h02, 8'h03, 8'hEA, 8'hFF:        w_kind = chd_pkg::MK_MBC1;
            8'h05, 8'h06:                             w_kind = chd_pkg::MK_MBC2;
            8'h0F, 8'h10, 8'h11, 8'h12, 8'h13, 8'hFC: w_kind = chd_pkg::MK_MBC3;
            8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E,
            8'h15, 8'h16, 8'h17, 8'h22:               w_kind = chd_pkg::MK_MBC5;
            8'h0B, 8'h0C, 8'h0D:                      w_kind = chd_pkg::MK_MULTI;
            default:                                  w_kind = chd_pkg::MK_UNSUP;
        endcase

        o_result = '0;

        if (w_kind == chd_pkg::MK_MBC1 && i_state.cart_type == chd_pkg::TYPE_MBC1
                && i_state.ram_code == 8'h00 && i_rom_banks == chd_pkg::MULTICART_BANKS) begin
            o_result.mapper_kind = chd_pkg::MK_MULTI;
        end else begin
            o_result.mapper_kind = w_kind;
        end

        unique case (w_type)
            8'h03, 8'h06, 8'h09, 8'h0D, 8'h0F, 8'h10, 8'h13,
            8'h17, 8'h1B, 8'h1E, 8'h22, 8'hFD, 8'hFF: o_result.has_battery = 1'b1;
            default:                                  o_result.has_battery = 1'b0;
        endcase

        o_result.has_clock  = (w_type == 8'h0F) || (w_type == 8'h10);
        o_result.has_rumble = (w_type >= 8'h1C) && (w_type <= 8'h1E);

        unique case (i_state.ram_code)
            8'h00:        o_result.ram_banks = (w_kind == chd_pkg::MK_MBC2) ? 5'd1 : 5'd0;
            8'h01, 8'h02: o_result.ram_banks = 5'd1;
            8'h04:        o_result.ram_banks = 5'd16;
            default:      o_result.ram_banks = 5'd4;
        endcase

        o_result.rom_banks = i_rom_banks;

        priority if (i_state.color_flag == chd_pkg::COLOR_ONLY) begin
            o_result.color_mode = chd_pkg::CM_ONLY;
        end else if (i_state.color_flag == chd_pkg::COLOR_SUPPORT) begin
            o_result.color_mode = chd_pkg::CM_SUPPORT;
        end else begin
            o_result.color_mode = chd_pkg::CM_MONO;
        end

        w_check                = i_state.sum + chd_pkg::SUM_BIAS;
        o_result.super_support = (i_state.super_flag == chd_pkg::SUPER_ENABLED);
        o_result.header_ok     = (w_check == 8'h00);
        o_result.version       = i_state.version;
        o_result.rom_size_code = i_state.rom_code;
        o_result.ram_size_code = i_state.ram_code;
    end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge header decoder testbench
// Streams header bytes into the decoder and predicts every decoded result
// in the bench itself. Each result beat is checked field by field against the
// oldest pending prediction. Directed tests cover the reset state, the
// multicart guess, the zero ROM size rule, the feature flags and an oversized
// image. Random traffic follows with mostly well-formed headers, short and
// broken sequences, and several image sizes under varying stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import chd_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [OFFSET_W-1:0]  i_byte_offset = '0;
    logic [7:0]           i_header_byte = '0;
    logic                 i_last_byte = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [2:0]           o_mapper_kind;
    logic                 o_has_battery;
    logic                 o_has_clock;
    logic                 o_has_rumble;
    logic [RAMB_W-1:0]    o_ram_banks;
    logic [BANKS_W-1:0]   o_rom_banks;
    logic [1:0]           o_color_mode;
    logic                 o_super_support;
    logic                 o_header_ok;
    logic [7:0]           o_version;
    logic [7:0]           o_rom_size_code;
    logic [7:0]           o_ram_size_code;

    t_hdr_state           hdr_state = '0;
    logic [BANKS_W-1:0]   cfg_image_banks = '0;
    t_hdr_result          pending_decodes[$];
    int                   mismatch_count = 0;
    int                   beats_sent = 0;
    int                   cycle_count = 0;
    int                   tx_idle_pct = 0;
    int                   rx_idle_pct = 0;

    logic [7:0] known_types [30] = '{
        8'h00, 8'h01, 8'h02, 8'h03, 8'h05, 8'h06, 8'h08, 8'h09, 8'h0B, 8'h0C,
        8'h0D, 8'h0F, 8'h10, 8'h11, 8'h12, 8'h13, 8'h15, 8'h16, 8'h17, 8'h19,
        8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E, 8'h22, 8'hEA, 8'hFC, 8'hFD, 8'hFF
    };
    logic [BANKS_W-1:0] bank_choices [12] = '{
        10'd0, 10'd1, 10'd2, 10'd3, 10'd33, 10'd64,
        10'd65, 10'd256, 10'd511, 10'd512, 10'd513, 10'd1023
    };

    cartridge_header_decoder u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_byte_offset   (i_byte_offset),
        .i_header_byte   (i_header_byte),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_mapper_kind   (o_mapper_kind),
        .o_has_battery   (o_has_battery),
        .o_has_clock     (o_has_clock),
        .o_has_rumble    (o_has_rumble),
        .o_ram_banks     (o_ram_banks),
        .o_rom_banks     (o_rom_banks),
        .o_color_mode    (o_color_mode),
        .o_super_support (o_super_support),
        .o_header_ok     (o_header_ok),
        .o_version       (o_version),
        .o_rom_size_code (o_rom_size_code),
        .o_ram_size_code (o_ram_size_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_mapper_kind mapper_of_type(logic [7:0] t);
        case (t)
            8'h00, 8'h08, 8'h09: return MK_NONE;
            8'h01, 8'h02, 8'h03, 8'hEA, 8'hFF: return MK_MBC1;
            8'h05, 8'h06: return MK_MBC2;
            8'h0F, 8'h10, 8'h11, 8'h12, 8'h13, 8'hFC: return MK_MBC3;
            8'h15, 8'h16, 8'h17, 8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E,
            8'h22: return MK_MBC5;
            8'h0B, 8'h0C, 8'h0D: return MK_MULTI;
            default: return MK_UNSUP;
        endcase
    endfunction

    function automatic t_hdr_result decode_header(t_hdr_state st,
                                                  logic [BANKS_W-1:0] banks);
        t_hdr_result r;
        logic [7:0]  t;
        logic [7:0]  biased;
        int unsigned span;
        int unsigned romb;
        t = st.cart_type;
        if (t != TYPE_MBC1_ALT && st.rom_code == 8'h00) begin
            t = TYPE_ROM_ONLY;
        end
        r.mapper_kind = mapper_of_type(t);
        case (st.ram_code)
            8'h00: r.ram_banks = (r.mapper_kind == MK_MBC2) ? 5'd1 : 5'd0;
            8'h01, 8'h02: r.ram_banks = 5'd1;
            8'h04: r.ram_banks = 5'd16;
            default: r.ram_banks = 5'd4;
        endcase
        span = (32'(banks) > MAX_IMAGE_BANKS) ? MAX_IMAGE_BANKS : 32'(banks);
        romb = 2;
        while (romb < span) romb = romb * 2;
        r.rom_banks = romb[BANKS_W-1:0];
        if (r.mapper_kind == MK_MBC1 && st.cart_type == TYPE_MBC1 &&
            st.ram_code == 8'h00 && r.rom_banks == MULTICART_BANKS) begin
            r.mapper_kind = MK_MULTI;
        end
        case (t)
            8'h03, 8'h06, 8'h09, 8'h0D, 8'h0F, 8'h10, 8'h13, 8'h17, 8'h1B,
            8'h1E, 8'h22, 8'hFD, 8'hFF: r.has_battery = 1'b1;
            default: r.has_battery = 1'b0;
        endcase
        r.has_clock = (t == 8'h0F || t == 8'h10);
        r.has_rumble = (t >= 8'h1C && t <= 8'h1E);
        if (st.color_flag == COLOR_ONLY) begin
            r.color_mode = CM_ONLY;
        end else if (st.color_flag == COLOR_SUPPORT) begin
            r.color_mode = CM_SUPPORT;
        end else begin
            r.color_mode = CM_MONO;
        end
        r.super_support = (st.super_flag == SUPER_ENABLED);
        biased = st.sum + SUM_BIAS;
        r.header_ok = (biased == 8'h00);
        r.version = st.version;
        r.rom_size_code = st.rom_code;
        r.ram_size_code = st.ram_code;
        return r;
    endfunction

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (act_v !== exp_v) begin
            if (mismatch_count < 10) begin
                $display("Mismatch in %s at cycle %0d: expected %0h, got %0h",
                         name, cycle_count, exp_v, act_v);
            end
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_hdr_result exp_r;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_decodes.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("Result beat with no header pending at cycle %0d",
                                 cycle_count);
                    end
                    mismatch_count++;
                end else begin
                    exp_r = pending_decodes.pop_front();
                    check_field("mapper_kind", 16'(exp_r.mapper_kind),
                                16'(o_mapper_kind));
                    check_field("has_battery", 16'(exp_r.has_battery),
                                16'(o_has_battery));
                    check_field("has_clock", 16'(exp_r.has_clock), 16'(o_has_clock));
                    check_field("has_rumble", 16'(exp_r.has_rumble), 16'(o_has_rumble));
                    check_field("ram_banks", 16'(exp_r.ram_banks), 16'(o_ram_banks));
                    check_field("rom_banks", 16'(exp_r.rom_banks), 16'(o_rom_banks));
                    check_field("color_mode", 16'(exp_r.color_mode), 16'(o_color_mode));
                    check_field("super_support", 16'(exp_r.super_support),
                                16'(o_super_support));
                    check_field("header_ok", 16'(exp_r.header_ok), 16'(o_header_ok));
                    check_field("version", 16'(exp_r.version), 16'(o_version));
                    check_field("rom_size_code", 16'(exp_r.rom_size_code),
                                16'(o_rom_size_code));
                    check_field("ram_size_code", 16'(exp_r.ram_size_code),
                                16'(o_ram_size_code));
                end
            end
            if (i_in_valid && o_in_ready) begin
                if (i_byte_offset <= OFF_LAST) begin
                    hdr_state.sum = hdr_state.sum + i_header_byte;
                    case (i_byte_offset)
                        OFF_COLOR:   hdr_state.color_flag = i_header_byte;
                        OFF_SUPER:   hdr_state.super_flag = i_header_byte;
                        OFF_TYPE:    hdr_state.cart_type = i_header_byte;
                        OFF_ROMSZ:   hdr_state.rom_code = i_header_byte;
                        OFF_RAMSZ:   hdr_state.ram_code = i_header_byte;
                        OFF_VERSION: hdr_state.version = i_header_byte;
                        default: ;
                    endcase
                end
                if (i_last_byte) begin
                    pending_decodes.push_back(decode_header(hdr_state, cfg_image_banks));
                    hdr_state.sum = 8'h00;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_beat(logic [OFFSET_W-1:0] off, logic [7:0] data, logic last);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_byte_offset <= off;
        i_header_byte <= data;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (off <= OFF_LAST || last) beats_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_decodes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_image_banks(logic [BANKS_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_IMAGE_BANKS, 2'b00};
        pwdata <= {{(APB_DW-BANKS_W){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_image_banks = value;
    endtask

    function automatic logic [7:0] biased_value(logic [OFFSET_W-1:0] off);
        logic [7:0] v;
        v = 8'($urandom_range(255));
        case (off)
            OFF_COLOR: begin
                case ($urandom_range(2))
                    0: v = COLOR_SUPPORT;
                    1: v = COLOR_ONLY;
                    default: ;
                endcase
            end
            OFF_SUPER: if ($urandom_range(1)) v = SUPER_ENABLED;
            OFF_TYPE: if ($urandom_range(9) < 7) v = known_types[5'($urandom_range(29))];
            OFF_ROMSZ: begin
                if ($urandom_range(4) == 0) begin
                    v = 8'h00;
                end else if ($urandom_range(1)) begin
                    v = 8'($urandom_range(8));
                end
            end
            OFF_RAMSZ: if ($urandom_range(9) < 7) v = 8'($urandom_range(5));
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_reset_state();
        send_beat(5'd31, 8'hA5, 1'b1);
        wait_idle();
    endtask

    task automatic test_multicart_guess();
        write_image_banks(10'd64);
        send_beat(OFF_TYPE, TYPE_MBC1, 1'b0);
        send_beat(OFF_ROMSZ, 8'h05, 1'b0);
        send_beat(OFF_LAST, 8'hE1, 1'b1);
        wait_idle();
    endtask

    task automatic test_forced_type();
        send_beat(OFF_ROMSZ, 8'h00, 1'b0);
        send_beat(OFF_TYPE, 8'h13, 1'b0);
        send_beat(OFF_LAST, 8'h00, 1'b1);
        send_beat(OFF_TYPE, TYPE_MBC1_ALT, 1'b0);
        send_beat(OFF_LAST, 8'h00, 1'b1);
        send_beat(OFF_ROMSZ, 8'h01, 1'b0);
        send_beat(OFF_TYPE, 8'h06, 1'b0);
        send_beat(OFF_LAST, 8'h00, 1'b1);
        wait_idle();
    endtask

    task automatic test_flags_and_capture();
        send_beat(OFF_COLOR, COLOR_ONLY, 1'b0);
        send_beat(OFF_SUPER, SUPER_ENABLED, 1'b0);
        send_beat(OFF_VERSION, 8'hFF, 1'b0);
        send_beat(OFF_RAMSZ, 8'h04, 1'b0);
        send_beat(OFF_TYPE, 8'h1C, 1'b0);
        send_beat(OFF_TYPE, 8'h1E, 1'b0);
        send_beat(5'd0, 8'hFF, 1'b0);
        send_beat(OFF_LAST, 8'hE8, 1'b1);
        send_beat(OFF_COLOR, COLOR_SUPPORT, 1'b0);
        send_beat(OFF_RAMSZ, 8'hFF, 1'b0);
        send_beat(OFF_TYPE, 8'h10, 1'b0);
        send_beat(OFF_LAST, 8'h00, 1'b1);
        wait_idle();
    endtask

    task automatic test_oversized_image();
        write_image_banks(10'd1023);
        send_beat(5'd31, 8'h00, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_traffic(int n_beats, int tx_pct, int rx_pct);
        int start;
        int seqs;
        int n;
        logic [7:0] img [26];
        logic [7:0] total;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start = beats_sent;
        seqs = 0;
        while (beats_sent - start < n_beats) begin
            case ($urandom_range(9))
                7, 8: begin
                    n = $urandom_range(1, 4);
                    repeat (n) begin
                        n = $urandom_range(OFF_COLOR, OFF_LAST);
                        send_beat(n[OFFSET_W-1:0], biased_value(n[OFFSET_W-1:0]), 1'b0);
                    end
                    send_beat(5'($urandom_range(31)), 8'($urandom_range(255)), 1'b1);
                end
                9: begin
                    n = $urandom_range(1, 6);
                    repeat (n) begin
                        send_beat(5'($urandom_range(31)), 8'($urandom_range(255)),
                                  $urandom_range(7) == 0);
                    end
                end
                default: begin
                    total = 8'h00;
                    for (int k = 0; k < 26; k++) img[5'(k)] = biased_value(5'(k));
                    for (int k = 0; k <= OFF_VERSION; k++) total = total + img[5'(k)];
                    if ($urandom_range(1)) img[OFF_LAST] = 8'h00 - total - SUM_BIAS;
                    for (int k = 0; k <= OFF_VERSION; k++) begin
                        send_beat(5'(k), img[5'(k)], 1'b0);
                        if ($urandom_range(19) == 0) begin
                            send_beat(5'($urandom_range(31)), 8'($urandom_range(255)),
                                      1'b0);
                        end
                    end
                    send_beat(OFF_LAST, img[OFF_LAST], 1'b1);
                end
            endcase
            seqs++;
            if (seqs % 6 == 0) begin
                wait_idle();
                if ($urandom_range(3) == 0) begin
                    write_image_banks(10'($urandom_range(1023)));
                end else begin
                    write_image_banks(bank_choices[4'($urandom_range(11))]);
                end
            end
        end
        wait_idle();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        tx_idle_pct = 11;
        rx_idle_pct = 65;
        test_reset_state();
        test_multicart_guess();
        test_forced_type();
        test_flags_and_capture();
        test_oversized_image();
        test_random_traffic(600, 11, 65);
        test_random_traffic(600, 65, 11);
        test_random_traffic(600, 0, 0);
        if (mismatch_count == 0 && pending_decodes.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/chd_pkg.sv
rtl/core/chd_cfg.sv
rtl/core/chd_capture.sv
rtl/core/chd_decode.sv
rtl/core/cartridge_header_decoder.sv
verif/tb_top.sv
